@@ design/route_table_range_lookup_assert.svh @@
// Assertion macros for the route table
`ifndef ROUTE_TABLE_RANGE_LOOKUP_ASSERT_SVH
`define ROUTE_TABLE_RANGE_LOOKUP_ASSERT_SVH
`define RTRL_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define RTRL_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ design/rtrl_pkg.sv @@
`default_nettype none
package rtrl_pkg;
  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_TUPLE = 3'd1, FN_FIRST = 3'd2,
    FN_BEST = 3'd3, FN_TICK = 3'd4, FN_COUNT = 3'd5
  } func_t;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [1:0] KIND_ROUTER = 2'd1;
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] net_start;
    logic [15:0] net_end;
    logic [7:0]  next_hop;
    logic [7:0]  hops;
    logic [15:0] metric;
    logic [1:0]  kind;
    logic        active;
    logic        stat;
    logic [15:0] net;
    logic [2:0]  early;   // status settled in front; ST_OK means go on
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_start;
    logic [15:0] found_end;
    logic [7:0]  found_next_hop;
    logic [7:0]  found_hops;
    logic [15:0] found_metric;
    logic [1:0]  found_kind;
    logic        found_active;
    logic        found_static;
    logic [31:0] found_uses;
    logic [6:0]  route_count;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_WRITE, S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ design/route_table_range_lookup.sv @@
// channel | direction | handshake
// in      | in        | in_valid / in_stall
// out     | out       | out_valid / out_stall
// cfg     | in        | cfg_we, cfg_index, cfg_data
// The back end scans the table one entry a cycle through the registered memory
// read port; a first-match hit ends the scan early. A count or a rejected item
// skips the scan.
// Tick compacts in the same pass, writing kept entries back one a cycle.
// Reset (rst, synchronous) empties the table and clears the clock.
// Two queued items are held while out_stall is high.
`default_nettype none
module route_table_range_lookup #(
  parameter int ROUTE_DEPTH = 64,
  parameter int HOP_LIMIT = 15
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [15:0] net_start,
  input  wire logic [15:0] net_end,
  input  wire logic [7:0]  next_hop,
  input  wire logic [7:0]  hops,
  input  wire logic [1:0]  route_kind,
  input  wire logic active_flag,
  input  wire logic static_flag,
  input  wire logic [15:0] metric,
  input  wire logic [15:0] lookup_network,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [2:0]  status,
  output logic [15:0] found_start,
  output logic [15:0] found_end,
  output logic [7:0]  found_next_hop,
  output logic [7:0]  found_hops,
  output logic [15:0] found_metric,
  output logic [1:0]  found_kind,
  output logic found_active,
  output logic found_static,
  output logic [31:0] found_uses,
  output logic [6:0]  route_count
);
  import rtrl_pkg::*;
  logic q_valid, q_pop;
  cmd_t q_cmd;
  res_t r;

  rtrl_front #(.HOP_LIMIT(HOP_LIMIT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .net_start, .net_end, .next_hop,
    .hops, .route_kind, .active_flag, .static_flag, .metric, .lookup_network,
    .q_valid, .q_cmd, .q_pop
  );
  rtrl_back #(.ROUTE_DEPTH(ROUTE_DEPTH)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_cmd, .q_pop,
    .r_valid(out_valid), .r_res(r), .r_take(!out_stall)
  );
  assign status = r.status; assign found_start = r.found_start;
  assign found_end = r.found_end; assign found_next_hop = r.found_next_hop;
  assign found_hops = r.found_hops; assign found_metric = r.found_metric;
  assign found_kind = r.found_kind; assign found_active = r.found_active;
  assign found_static = r.found_static; assign found_uses = r.found_uses;
  assign route_count = r.route_count;
endmodule
`default_nettype wire

@@ design/rtrl_front.sv @@
`default_nettype none
module rtrl_front #(
  parameter int HOP_LIMIT = 15
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [15:0] net_start,
  input  wire logic [15:0] net_end,
  input  wire logic [7:0]  next_hop,
  input  wire logic [7:0]  hops,
  input  wire logic [1:0]  route_kind,
  input  wire logic active_flag,
  input  wire logic static_flag,
  input  wire logic [15:0] metric,
  input  wire logic [15:0] lookup_network,
  output logic      q_valid,
  output rtrl_pkg::cmd_t q_cmd,
  input  wire logic q_pop
);
  import rtrl_pkg::*;
  localparam logic [7:0] HL = 8'(HOP_LIMIT);
  // two-entry queue
  cmd_t slot [2];
  logic [1:0] cnt;
  logic rd, wr;
  cmd_t c;
  logic push;

  always_comb begin
    c = '0;
    c.func = func; c.net = lookup_network; c.early = ST_OK;
    c.net_start = net_start; c.net_end = net_end; c.next_hop = next_hop;
    c.hops = hops; c.metric = metric; c.kind = route_kind;
    c.active = active_flag; c.stat = static_flag;
    case (func)
      FN_ADD: if (net_start > net_end || hops > HL) c.early = ST_INVALID;
      FN_TUPLE: begin
        if (net_start == '0 || hops >= HL) c.early = ST_IGNORED;
        c.net_end = net_start;
        c.hops = hops + 8'd1;
        c.metric = {8'd0, hops + 8'd1};
        c.kind = KIND_ROUTER; c.active = 1'b1; c.stat = 1'b0;
      end
      FN_FIRST, FN_BEST, FN_TICK, FN_COUNT: ;
      default: c.early = ST_INVALID;
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; wr <= 1'b0;
    end else begin
      if (push) begin
        slot[wr] <= c; wr <= ~wr;
      end
      if (q_pop) rd <= ~rd;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

@@ design/rtrl_back.sv @@
`default_nettype none
`include "route_table_range_lookup_assert.svh"
module rtrl_back #(
  parameter int ROUTE_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic q_valid,
  input  rtrl_pkg::cmd_t q_cmd,
  output logic      q_pop,
  output logic      r_valid,
  output rtrl_pkg::res_t r_res,
  input  wire logic r_take
);
  import rtrl_pkg::*;
  localparam int AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int CW = $clog2(ROUTE_DEPTH + 1);

  logic [31:0] range_mem [ROUTE_DEPTH];
  logic [37:0] info_mem  [ROUTE_DEPTH];
  logic [31:0] stamp_mem [ROUTE_DEPTH];
  logic [31:0] use_mem   [ROUTE_DEPTH];

  logic [15:0] timeout;
  logic [6:0]  limit;
  logic [CW-1:0] count, count_next;
  logic [31:0] now, now_next;
  state_t state, state_next;
  cmd_t cmd;
  logic [CW-1:0] ptr, ptr_next, wptr, wptr_next;
  logic [31:0] rg_q, st_q, us_q;
  logic [37:0] in_q;
  logic rd_ok;          // read data valid for ptr-1
  logic rd_ok_next;
  logic hit, hit_next;
  logic [AW-1:0] hidx, hidx_next;
  logic [15:0] hmet, hmet_next;
  res_t res_next;
  logic ld;
  // write request
  logic we, we_next;
  logic [AW-1:0] wa, wa_next;
  logic [31:0] wrg, wst, wus, wrg_next, wst_next, wus_next;
  logic [37:0] winf, winf_next;
  logic [CW-1:0] lim_eff;
  logic [AW-1:0] raddr;
  logic cov, keep;
  logic [31:0] age;

  assign lim_eff = ({25'd0, limit} > 32'(ROUTE_DEPTH)) ? CW'(ROUTE_DEPTH) : CW'(limit);
  assign raddr = (state == S_READ) ? hidx : ptr[AW-1:0];
  assign cov = cmd.func == FN_ADD || cmd.func == FN_TUPLE
             ? (cmd.net_start >= rg_q[31:16] && cmd.net_start <= rg_q[15:0] && in_q[34])
             : (cmd.net >= rg_q[31:16] && cmd.net <= rg_q[15:0] && in_q[34]);
  assign age = now - st_q;
  assign keep = in_q[35] || !(age > {16'd0, timeout});

  always_ff @(posedge clk) begin
    rg_q <= range_mem[raddr]; in_q <= info_mem[raddr];
    st_q <= stamp_mem[raddr]; us_q <= use_mem[raddr];
    if (we) begin
      range_mem[wa] <= wrg; info_mem[wa] <= winf;
      stamp_mem[wa] <= wst; use_mem[wa] <= wus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; now <= '0; r_valid <= 1'b0;
      timeout <= 16'd180; limit <= 7'd64; we <= 1'b0;
    end else begin
      state <= state_next; count <= count_next; now <= now_next;
      we <= we_next;
      if (ld) r_valid <= 1'b1;
      else if (r_take) r_valid <= 1'b0;
      if (cfg_we && cfg_index == CFG_TIMEOUT) timeout <= cfg_data;
      if (cfg_we && cfg_index == CFG_LIMIT) limit <= cfg_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    ptr <= ptr_next; wptr <= wptr_next; rd_ok <= rd_ok_next;
    hit <= hit_next; hidx <= hidx_next; hmet <= hmet_next;
    wa <= wa_next; wrg <= wrg_next; winf <= winf_next;
    wst <= wst_next; wus <= wus_next;
    // r_valid is low while an item runs, so the result may settle here early
    if (ld || state == S_WRITE) r_res <= res_next;
  end

  always_comb begin
    state_next = state; count_next = count; now_next = now;
    ptr_next = ptr; wptr_next = wptr; rd_ok_next = 1'b0;
    hit_next = hit; hidx_next = hidx; hmet_next = hmet;
    we_next = 1'b0; wa_next = wa; wrg_next = wrg; winf_next = winf;
    wst_next = wst; wus_next = wus;
    q_pop = 1'b0; ld = 1'b0; res_next = r_res;
    unique case (state)
      S_IDLE: begin
        if (q_valid && !r_valid) begin
          q_pop = 1'b1; ptr_next = '0; wptr_next = '0; hit_next = 1'b0;
          if (q_cmd.func == FN_TICK) now_next = now + 32'd1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // read issued at ptr; data for ptr-1 is checked when rd_ok
        if (cmd.early != ST_OK || cmd.func == FN_COUNT) begin
          state_next = S_DONE;
        end else begin
          if (rd_ok) begin
            if (cmd.func == FN_TICK) begin
              if (keep) begin
                we_next = 1'b1; wa_next = wptr[AW-1:0]; wrg_next = rg_q;
                winf_next = in_q; wst_next = st_q; wus_next = us_q;
                wptr_next = wptr + 1'b1;
              end
            end else if (cov && (!hit || (cmd.func == FN_BEST && in_q[31:16] < hmet))) begin
              hit_next = 1'b1; hidx_next = AW'(ptr - 1'b1); hmet_next = in_q[31:16];
            end
          end
          if (ptr < count && !(hit_next && cmd.func != FN_BEST)) begin
            ptr_next = ptr + 1'b1; rd_ok_next = 1'b1;
          end else if (!rd_ok || (hit_next && cmd.func != FN_BEST)) begin
            state_next = (cmd.func == FN_TICK) ? S_WRITE : S_READ;
          end
        end
      end
      S_READ: begin
        // wait for the registered read of the hit entry's data
        state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_DONE;
        res_next = '0; res_next.status = ST_OK;
        if (cmd.func == FN_TICK) begin
          count_next = wptr;
        end else if (cmd.func == FN_FIRST || cmd.func == FN_BEST) begin
          if (!hit) res_next.status = ST_NOT_FOUND;
          else begin
            res_next.found_start = rg_q[31:16]; res_next.found_end = rg_q[15:0];
            res_next.found_next_hop = in_q[7:0]; res_next.found_hops = in_q[15:8];
            res_next.found_metric = in_q[31:16]; res_next.found_kind = in_q[33:32];
            res_next.found_active = in_q[34]; res_next.found_static = in_q[35];
            res_next.found_uses = us_q;
            we_next = 1'b1; wa_next = hidx; wrg_next = rg_q; winf_next = in_q;
            wst_next = st_q; wus_next = us_q + 32'd1;
          end
        end else begin
          wrg_next = {cmd.net_start, cmd.net_end};
          winf_next = {2'b00, cmd.stat, cmd.active, cmd.kind, cmd.metric, cmd.hops,
                       cmd.next_hop};
          wst_next = now; wus_next = '0;
          if (hit) begin
            if (cmd.metric < in_q[31:16] || cmd.stat) begin
              we_next = 1'b1; wa_next = hidx;
            end
          end else if (count >= lim_eff) begin
            res_next.status = ST_FULL;
          end else begin
            we_next = 1'b1; wa_next = count[AW-1:0]; count_next = count + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (cmd.early != ST_OK) begin
          res_next = '0; res_next.status = cmd.early;
        end else if (cmd.func == FN_COUNT) begin
          res_next = '0; res_next.status = ST_OK;
        end
        res_next.route_count = 7'(count);
        ld = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `RTRL_ASSERT_IMPLY(a_pop_idle, clk, rst, q_pop, state == S_IDLE && !r_valid)
  `RTRL_ASSERT_IMPLY(a_count_max, clk, rst, 1'b1, count <= CW'(ROUTE_DEPTH))
  `RTRL_ASSERT_NEXT(a_ld_valid, clk, rst, ld, r_valid)
endmodule
`default_nettype wire
